[sv/dipi_pkg.sv]
// Package for the dual-wheel incremental PI motor drive.
// Holds register codes, direction and bridge pin codes, reset values and the
// per-wheel PI update function. No dependencies.

package dipi_pkg;

   // Field widths
   localparam int SpeedW = 12;
   localparam int ErrW   = 13;
   localparam int DriveW = 8;
   localparam int GainW  = 16;
   localparam int PinsW  = 4;
   localparam int DirW   = 3;
   localparam int CsrIdxW = 2;

   // Register reset values
   localparam logic [GainW-1:0]  PropGainRst  = 16'd256;
   localparam logic [GainW-1:0]  IntegGainRst = 16'd64;
   localparam logic [SpeedW-1:0] FullSpeedRst = 12'd1000;

   // Configuration register indexes
   typedef enum logic [CsrIdxW-1:0] {
      REG_PROP_GAIN  = 2'd0,
      REG_INTEG_GAIN = 2'd1,
      REG_FULL_SPEED = 2'd2
   } reg_type;

   // Direction commands; codes 6 and 7 mean stop
   typedef enum logic [DirW-1:0] {
      DIR_FORWARD = 3'd0,
      DIR_REVERSE = 3'd1,
      DIR_RIGHT   = 3'd2,
      DIR_LEFT    = 3'd3,
      DIR_ROT_CW  = 3'd4,
      DIR_ROT_CCW = 3'd5
   } dir_type;

   // H-bridge levels: bit0 IN1A, bit1 IN2A, bit2 IN1B, bit3 IN2B
   localparam logic [PinsW-1:0] PinsForward = 4'h5;
   localparam logic [PinsW-1:0] PinsReverse = 4'hA;
   localparam logic [PinsW-1:0] PinsRight   = 4'h1;
   localparam logic [PinsW-1:0] PinsLeft    = 4'h4;
   localparam logic [PinsW-1:0] PinsRotCw   = 4'h9;
   localparam logic [PinsW-1:0] PinsRotCcw  = 4'h6;
   localparam logic [PinsW-1:0] PinsStop    = 4'h0;

   // New drive and error of one wheel
   typedef struct packed {
      logic [DriveW-1:0]      drive;
      logic signed [ErrW-1:0] err;
   } wheel_type;

   // One velocity-form PI update; all divisions truncate toward zero
   function automatic wheel_type pi_step(
      input logic [SpeedW-1:0]      target,
      input logic [SpeedW-1:0]      speed,
      input logic [GainW-1:0]       kp,
      input logic [GainW-1:0]       ki,
      input logic [DriveW-1:0]      last_drive,
      input logic signed [ErrW-1:0] last_err
   );
      wheel_type          res;
      logic signed [12:0] err;
      logic signed [13:0] delta;
      logic signed [13:0] esum;
      logic signed [13:0] esum_adj;
      logic signed [12:0] mean;
      logic signed [30:0] prod_p;
      logic signed [30:0] prod_p_adj;
      logic signed [29:0] prod_i;
      logic signed [29:0] prod_i_adj;
      logic signed [22:0] p_term;
      logic signed [21:0] i_term;
      logic signed [24:0] total;

      err   = $signed({1'b0, target}) - $signed({1'b0, speed});
      delta = {err[12], err} - {last_err[12], last_err};
      esum  = {err[12], err} + {last_err[12], last_err};

      // Halve toward zero: bias negative sums by one before the shift
      esum_adj = esum + {13'd0, esum[13]};
      mean     = esum_adj[13:1];

      prod_p = $signed({1'b0, kp}) * delta;
      prod_i = $signed({1'b0, ki}) * mean;

      // Divide by 256 toward zero
      prod_p_adj = prod_p + (prod_p[30] ? 31'sd255 : 31'sd0);
      prod_i_adj = prod_i + (prod_i[29] ? 30'sd255 : 30'sd0);
      p_term     = prod_p_adj[30:8];
      i_term     = prod_i_adj[29:8];

      total = {17'd0, last_drive} + {{2{p_term[22]}}, p_term}
            + {{3{i_term[21]}}, i_term};

      // Saturate to 0..255
      if (total[24]) begin
         res.drive = '0;
      end else if (|total[23:8]) begin
         res.drive = '1;
      end else begin
         res.drive = total[7:0];
      end
      res.err = err;
      return res;
   endfunction

endpackage

[sv/dual_incremental_pi_motor_drive.sv]
// Requests move from the input register to the result register that drives rsp_valid.
// Throughput: one request per cycle when not stalled; the input and result registers
// each hold one request, so a new request enters while a result waits on rsp_stall.
// Per-wheel state (previous drive and error) updates in the cycle the result is formed.
// Reset (synchronous, active high) clears both stages and the wheel state and loads
// the gain and speed registers with their defaults; csr writes are always ready.
// Depends on dipi_pkg.

module dual_incremental_pi_motor_drive (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [dipi_pkg::DirW-1:0]    req_direction,
   input  logic [dipi_pkg::SpeedW-1:0]  req_speed_left,
   input  logic [dipi_pkg::SpeedW-1:0]  req_speed_right,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [dipi_pkg::DriveW-1:0]  rsp_drive_left,
   output logic [dipi_pkg::DriveW-1:0]  rsp_drive_right,
   output logic [dipi_pkg::PinsW-1:0]   rsp_bridge_pins,
   // configuration write channel
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [dipi_pkg::CsrIdxW-1:0] csr_index,
   input  logic [dipi_pkg::GainW-1:0]   csr_wdata
);

   // Configuration registers
   logic [dipi_pkg::GainW-1:0]  prop_gain_ff, prop_gain_in;
   logic [dipi_pkg::GainW-1:0]  integ_gain_ff, integ_gain_in;
   logic [dipi_pkg::SpeedW-1:0] full_speed_ff, full_speed_in;

   // Input stage
   logic                        in_vld_ff, in_vld_in;
   logic [dipi_pkg::DirW-1:0]   in_dir_ff, in_dir_in;
   logic [dipi_pkg::SpeedW-1:0] in_spd_l_ff, in_spd_l_in;
   logic [dipi_pkg::SpeedW-1:0] in_spd_r_ff, in_spd_r_in;

   // Result stage
   logic                        out_vld_ff, out_vld_in;
   logic [dipi_pkg::DriveW-1:0] out_drv_l_ff, out_drv_l_in;
   logic [dipi_pkg::DriveW-1:0] out_drv_r_ff, out_drv_r_in;
   logic [dipi_pkg::PinsW-1:0]  out_pins_ff, out_pins_in;

   // Wheel state
   logic [dipi_pkg::DriveW-1:0]      last_drive_left_ff, last_drive_left_in;
   logic [dipi_pkg::DriveW-1:0]      last_drive_right_ff, last_drive_right_in;
   logic signed [dipi_pkg::ErrW-1:0] last_error_left_ff, last_error_left_in;
   logic signed [dipi_pkg::ErrW-1:0] last_error_right_ff, last_error_right_in;

   logic                        fire;
   logic                        req_take;
   logic [dipi_pkg::SpeedW-1:0] half_speed;
   logic [dipi_pkg::SpeedW-1:0] tgt_l, tgt_r;
   logic [dipi_pkg::PinsW-1:0]  pins;
   dipi_pkg::wheel_type         wheel_l, wheel_r;

   // Handshake: the input stage moves to the result stage when that one is free
   assign fire      = in_vld_ff & (~out_vld_ff | ~rsp_stall);
   assign req_stall = in_vld_ff & ~fire;
   assign req_take  = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid       = out_vld_ff;
   assign rsp_drive_left  = out_drv_l_ff;
   assign rsp_drive_right = out_drv_r_ff;
   assign rsp_bridge_pins = out_pins_ff;

   // Configuration writes; unknown index is ignored
   always_comb begin
      prop_gain_in  = prop_gain_ff;
      integ_gain_in = integ_gain_ff;
      full_speed_in = full_speed_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dipi_pkg::REG_PROP_GAIN:  prop_gain_in  = csr_wdata;
            dipi_pkg::REG_INTEG_GAIN: integ_gain_in = csr_wdata;
            dipi_pkg::REG_FULL_SPEED: full_speed_in = csr_wdata[dipi_pkg::SpeedW-1:0];
            default: ;
         endcase
      end
   end

   // Direction decode: pin levels and wheel targets
   assign half_speed = {1'b0, full_speed_ff[dipi_pkg::SpeedW-1:1]};

   always_comb begin
      unique case (in_dir_ff)
         dipi_pkg::DIR_FORWARD: begin
            pins = dipi_pkg::PinsForward; tgt_l = half_speed; tgt_r = half_speed;
         end
         dipi_pkg::DIR_REVERSE: begin
            pins = dipi_pkg::PinsReverse; tgt_l = half_speed; tgt_r = half_speed;
         end
         dipi_pkg::DIR_RIGHT: begin
            pins = dipi_pkg::PinsRight; tgt_l = full_speed_ff; tgt_r = '0;
         end
         dipi_pkg::DIR_LEFT: begin
            pins = dipi_pkg::PinsLeft; tgt_l = '0; tgt_r = full_speed_ff;
         end
         dipi_pkg::DIR_ROT_CW: begin
            pins = dipi_pkg::PinsRotCw; tgt_l = half_speed; tgt_r = half_speed;
         end
         dipi_pkg::DIR_ROT_CCW: begin
            pins = dipi_pkg::PinsRotCcw; tgt_l = half_speed; tgt_r = half_speed;
         end
         default: begin
            // unused codes stop both wheels
            pins = dipi_pkg::PinsStop; tgt_l = '0; tgt_r = '0;
         end
      endcase
   end

   // PI update for both wheels
   assign wheel_l = dipi_pkg::pi_step(tgt_l, in_spd_l_ff, prop_gain_ff, integ_gain_ff,
                                      last_drive_left_ff, last_error_left_ff);
   assign wheel_r = dipi_pkg::pi_step(tgt_r, in_spd_r_ff, prop_gain_ff, integ_gain_ff,
                                      last_drive_right_ff, last_error_right_ff);

   // Next state of the stages and the wheel state
   always_comb begin
      in_vld_in   = req_take | (in_vld_ff & ~fire);
      in_dir_in   = in_dir_ff;
      in_spd_l_in = in_spd_l_ff;
      in_spd_r_in = in_spd_r_ff;
      if (req_take) begin
         in_dir_in   = req_direction;
         in_spd_l_in = req_speed_left;
         in_spd_r_in = req_speed_right;
      end

      out_vld_in          = fire | (out_vld_ff & rsp_stall);
      out_drv_l_in        = out_drv_l_ff;
      out_drv_r_in        = out_drv_r_ff;
      out_pins_in         = out_pins_ff;
      last_drive_left_in  = last_drive_left_ff;
      last_drive_right_in = last_drive_right_ff;
      last_error_left_in  = last_error_left_ff;
      last_error_right_in = last_error_right_ff;
      if (fire) begin
         out_drv_l_in        = wheel_l.drive;
         out_drv_r_in        = wheel_r.drive;
         out_pins_in         = pins;
         last_drive_left_in  = wheel_l.drive;
         last_drive_right_in = wheel_r.drive;
         last_error_left_in  = wheel_l.err;
         last_error_right_in = wheel_r.err;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff        <= dipi_pkg::PropGainRst;
         integ_gain_ff       <= dipi_pkg::IntegGainRst;
         full_speed_ff       <= dipi_pkg::FullSpeedRst;
         in_vld_ff           <= 1'b0;
         out_vld_ff          <= 1'b0;
         last_drive_left_ff  <= '0;
         last_drive_right_ff <= '0;
         last_error_left_ff  <= '0;
         last_error_right_ff <= '0;
      end else begin
         prop_gain_ff        <= prop_gain_in;
         integ_gain_ff       <= integ_gain_in;
         full_speed_ff       <= full_speed_in;
         in_vld_ff           <= in_vld_in;
         out_vld_ff          <= out_vld_in;
         last_drive_left_ff  <= last_drive_left_in;
         last_drive_right_ff <= last_drive_right_in;
         last_error_left_ff  <= last_error_left_in;
         last_error_right_ff <= last_error_right_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_dir_ff    <= in_dir_in;
      in_spd_l_ff  <= in_spd_l_in;
      in_spd_r_ff  <= in_spd_r_in;
      out_drv_l_ff <= out_drv_l_in;
      out_drv_r_ff <= out_drv_r_in;
      out_pins_ff  <= out_pins_in;
   end

   // Stall only when both stages are full and the result is held
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_vld_ff && out_vld_ff && rsp_stall))
      else $error("request stalled with a free stage");

   // A pending request is never dropped
   a_in_kept: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !fire) |=> in_vld_ff)
      else $error("pending request lost");

   // Presented drives match the stored wheel state right after an update
   a_drive_state: assert property (@(posedge clock) disable iff (reset)
      fire |=> (rsp_valid && rsp_drive_left == last_drive_left_ff
                && rsp_drive_right == last_drive_right_ff))
      else $error("result drive differs from stored drive");

   // Wheel state only moves on an update
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> ($stable(last_drive_left_ff) && $stable(last_drive_right_ff)
                 && $stable(last_error_left_ff) && $stable(last_error_right_ff)))
      else $error("wheel state changed without an update");

endmodule
